@@ rtl/core/mrte_pkg.sv @@
// ----------------------------------------------------------------------------
// mrte_pkg
// Shared types and constants of the repeat timer engine: operation codes,
// fixed field widths and the sequencer states.
// ----------------------------------------------------------------------------
package mrte_pkg;

   localparam int OP_W       = 2;
   localparam int SLOT_FLD_W = 4;
   localparam int INTERVAL_W = 24;
   localparam int FIRINGS_W  = 16;
   localparam int ELAPSED_W  = 16;

   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [FIRINGS_W-1:0] FIRINGS_ENDLESS = 16'hFFFF;
   localparam logic [FIRINGS_W-1:0] FIRINGS_SIGN    = 16'h8000;
   localparam logic [FIRINGS_W-1:0] FIRINGS_ONE     = 16'h0001;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

endpackage

@@ rtl/core/mrte_slot_mem.sv @@
// ----------------------------------------------------------------------------
// mrte_slot_mem
// Slot table storage: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mrte_slot_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/multi_slot_repeat_timer_engine.sv @@
// ----------------------------------------------------------------------------
// multi_slot_repeat_timer_engine
// Table of repeating timer slots that count ticks or milliseconds and report
// the slots that expire on each tick.
// ----------------------------------------------------------------------------
// Add and remove give no result. A tick holds req_stall high until its sweep
// and flush are done, longer while a result waits on rsp_stall and another
// expiry is already queued: the slot table sits in a synchronous memory
// with one write and one read port that is swept once for tick-counting
// slots and once for millisecond slots, one slot per cycle while no fired
// slot waits on a stalled queue. Slot occupancy lives in flip-flops cleared
// by reset, so no clearing pass follows reset. Results of a tick come out
// tick-counting slots first, each group in ascending slot order, with
// rsp_last on the final one; a tick that expires nothing gives none.
// ----------------------------------------------------------------------------
module multi_slot_repeat_timer_engine #(
   parameter int SLOT_COUNT  = 16,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mrte_pkg::OP_W-1:0]           req_op,
   input  logic [mrte_pkg::SLOT_FLD_W-1:0]     req_slot,
   input  logic                                req_kind,
   input  logic [mrte_pkg::INTERVAL_W-1:0]     req_interval,
   input  logic signed [mrte_pkg::FIRINGS_W-1:0] req_repeat_count,
   input  logic [mrte_pkg::ELAPSED_W-1:0]      req_elapsed_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mrte_pkg::SLOT_FLD_W-1:0]     rsp_fired_slot,
   output logic                                rsp_fired_kind,
   output logic                                rsp_last
);

   import mrte_pkg::*;

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int CW      = COUNT_WIDTH;
   localparam int ENTRY_W = 1 + FIRINGS_W + 2 * CW;
   localparam int CMP_W   = (CW > ELAPSED_W) ? CW : ELAPSED_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   state_type state_ff, state_in;

   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [SLOT_W-1:0]     iss_slot_ff, iss_slot_in;
   logic                  iss_pass_ff, iss_pass_in;
   logic                  iss_done_ff, iss_done_in;
   logic                  b_valid_ff, b_valid_in;
   logic [SLOT_W-1:0]     b_slot_ff, b_slot_in;
   logic                  b_pass_ff, b_pass_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic                  pend_kind_ff, pend_kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FLD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  sweep_en;
   logic                  flush_en;
   logic                  accept;
   logic                  slot_hit;
   logic [SLOT_W-1:0]     req_idx;

   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [SLOT_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]    rd_data;

   logic [CW-1:0]         rd_cd;
   logic [CW-1:0]         rd_rl;
   logic [FIRINGS_W-1:0]  rd_fl;
   logic                  rd_kind;
   logic [ELAPSED_W-1:0]  amount;
   logic                  b_active;
   logic                  b_fire;
   logic                  b_final;
   logic                  b_hold;
   logic                  out_free;
   logic [CW-1:0]         new_cd;
   logic [FIRINGS_W-1:0]  new_fl;

   mrte_slot_mem #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (ENTRY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept   = req_valid && !req_stall;
   assign slot_hit = 32'(req_slot) < SLOT_COUNT;
   assign req_idx  = SLOT_W'(req_slot);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rd_cd   = rd_data[CW-1:0];
   assign rd_rl   = rd_data[2*CW-1:CW];
   assign rd_fl   = rd_data[2*CW+FIRINGS_W-1:2*CW];
   assign rd_kind = rd_data[ENTRY_W-1];

   // drain one slot
   always_comb begin
      amount   = b_pass_ff ? elapsed_ff : ELAPSED_W'(1);
      b_active = sweep_en && b_valid_ff && valid_ff[b_slot_ff] && (rd_kind == b_pass_ff);
      b_fire   = b_active && (CMP_W'(rd_cd) <= CMP_W'(amount));
      b_final  = (rd_fl != FIRINGS_ENDLESS) &&
                 ((rd_fl <= FIRINGS_ONE) || (rd_fl >= FIRINGS_SIGN));
      b_hold   = b_fire && pend_valid_ff && !out_free;
      new_cd   = b_fire ? rd_rl : CW'(CMP_W'(rd_cd) - CMP_W'(amount));
      new_fl   = (b_fire && (rd_fl != FIRINGS_ENDLESS)) ? rd_fl - FIRINGS_ONE : rd_fl;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_TICK)) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (iss_done_ff && !b_hold) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      sweep_en  = 1'b0;
      flush_en  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SWEEP: sweep_en  = 1'b1;
         ST_FLUSH: flush_en  = 1'b1;
         default:  req_stall = 1'b1;
      endcase
   end

   // issue, table writes, queue and output
   always_comb begin
      valid_in      = valid_ff;
      elapsed_in    = elapsed_ff;
      iss_slot_in   = iss_slot_ff;
      iss_pass_in   = iss_pass_ff;
      iss_done_in   = iss_done_ff;
      b_valid_in    = b_valid_ff;
      b_slot_in     = b_slot_ff;
      b_pass_in     = b_pass_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_kind_in  = pend_kind_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = iss_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = req_idx;
      wr_data       = {req_kind, req_repeat_count, CW'(req_interval), CW'(req_interval)};

      if (accept) begin
         case (req_op)
            OP_TICK: begin
               elapsed_in  = req_elapsed_ms;
               iss_slot_in = '0;
               iss_pass_in = 1'b0;
               iss_done_in = 1'b0;
               b_valid_in  = 1'b0;
            end
            OP_ADD: begin
               if (slot_hit) begin
                  wr_en             = 1'b1;
                  valid_in[req_idx] = 1'b1;
               end
            end
            OP_REMOVE: begin
               if (slot_hit) begin
                  valid_in[req_idx] = 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (sweep_en) begin
         if (b_hold) begin
            rd_addr = b_slot_ff;
         end else begin
            if (b_active) begin
               wr_en   = 1'b1;
               wr_addr = b_slot_ff;
               wr_data = {rd_kind, new_fl, rd_rl, new_cd};
               if (b_fire && b_final) begin
                  valid_in[b_slot_ff] = 1'b0;
               end
            end
            if (b_fire) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = SLOT_FLD_W'(pend_slot_ff);
                  rsp_kind_in  = pend_kind_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = b_slot_ff;
               pend_kind_in  = b_pass_ff;
            end
            b_valid_in = !iss_done_ff;
            b_slot_in  = iss_slot_ff;
            b_pass_in  = iss_pass_ff;
            if (!iss_done_ff) begin
               if (iss_slot_ff == LAST_SLOT) begin
                  iss_slot_in = '0;
                  iss_pass_in = 1'b1;
                  iss_done_in = iss_pass_ff;
               end else begin
                  iss_slot_in = iss_slot_ff + SLOT_W'(1);
               end
            end
         end
      end

      if (flush_en && pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = SLOT_FLD_W'(pend_slot_ff);
         rsp_kind_in   = pend_kind_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         iss_done_ff   <= 1'b1;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         b_valid_ff    <= b_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         iss_done_ff   <= iss_done_in;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff   <= elapsed_in;
      iss_slot_ff  <= iss_slot_in;
      iss_pass_ff  <= iss_pass_in;
      b_slot_ff    <= b_slot_in;
      b_pass_ff    <= b_pass_in;
      pend_slot_ff <= pend_slot_in;
      pend_kind_ff <= pend_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_slot = rsp_slot_ff;
   assign rsp_fired_kind = rsp_kind_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

@@ rtl/core/mrte_checker.sv @@
// ----------------------------------------------------------------------------
// mrte_checker
// Port-level checks of the repeat timer engine, bound to the top level.
// ----------------------------------------------------------------------------
module mrte_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [mrte_pkg::OP_W-1:0]             req_op,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [mrte_pkg::SLOT_FLD_W-1:0]       rsp_fired_slot,
   input logic                                  rsp_fired_kind,
   input logic                                  rsp_last
);

   import mrte_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fired_slot) &&
         $stable(rsp_fired_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_TICK) |=> req_stall)
      else $error("tick transfer did not start a sweep");

   a_edit_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_ADD || req_op == OP_REMOVE)
         |=> !req_stall)
      else $error("add or remove did not finish in one cycle");

   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      !req_stall && rsp_valid |-> rsp_last)
      else $error("idle with a non-final result waiting");

endmodule

bind multi_slot_repeat_timer_engine mrte_checker u_mrte_checker (.*);

@@ test/tb_multi_slot_repeat_timer_engine.sv @@
// ----------------------------------------------------------------------------
// tb_multi_slot_repeat_timer_engine
// Self-checking bench for the repeat timer engine. A queue of add, remove and
// tick requests feeds a clocked driver. A local copy of the slot table
// predicts the expiries that each accepted tick reports. A clocked monitor
// compares every result transfer, field by field, with the oldest prediction.
// Both channels idle at random. One long response hold-off fills the engine
// and backs up its request side. Some requests wait until all results drain.
// ----------------------------------------------------------------------------
module tb_multi_slot_repeat_timer_engine;
   import mrte_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int TIMER_SLOTS   = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 100;
   localparam int CLOCK_PERIOD  = 20;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int TARGET_ITEMS  = 360;
   localparam int PRINT_CAP     = 50;

   typedef struct {
      logic [OP_W-1:0]              op;
      logic [SLOT_FLD_W-1:0]        slot;
      logic                         kind;
      logic [INTERVAL_W-1:0]        interval;
      logic signed [FIRINGS_W-1:0]  repeat_count;
      logic [ELAPSED_W-1:0]         elapsed_ms;
      bit                           drain_first;
      bit                           calm;
      bit                           hold;
   } timer_req_t;

   typedef struct {
      logic [SLOT_FLD_W-1:0] slot;
      logic                  kind;
      logic                  last;
   } fire_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_W-1:0] req_op = OP_TICK;
   logic [SLOT_FLD_W-1:0] req_slot = '0;
   logic req_kind = 1'b0;
   logic [INTERVAL_W-1:0] req_interval = '0;
   logic signed [FIRINGS_W-1:0] req_repeat_count = '0;
   logic [ELAPSED_W-1:0] req_elapsed_ms = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [SLOT_FLD_W-1:0] rsp_fired_slot;
   logic rsp_fired_kind;
   logic rsp_last;

   timer_req_t pending[$];
   fire_t      expected_fires[$];
   timer_req_t cur_req;
   int         gap_left = 0;
   bit         calm = 1'b0;
   bit         hold_req = 1'b0;
   bit         hold_done = 1'b0;
   int         hold_left = 0;
   int         stall_left = 0;
   int         errors = 0;

   bit                    tbl_valid [TIMER_SLOTS];
   bit                    tbl_kind [TIMER_SLOTS];
   logic [INTERVAL_W-1:0] tbl_count [TIMER_SLOTS];
   logic [INTERVAL_W-1:0] tbl_reload [TIMER_SLOTS];
   logic [FIRINGS_W-1:0]  tbl_left [TIMER_SLOTS];

   multi_slot_repeat_timer_engine uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_kind         (req_kind),
      .req_interval     (req_interval),
      .req_repeat_count (req_repeat_count),
      .req_elapsed_ms   (req_elapsed_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fired_slot   (rsp_fired_slot),
      .rsp_fired_kind   (rsp_fired_kind),
      .rsp_last         (rsp_last)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   function automatic timer_req_t noise_req(logic [OP_W-1:0] op);
      timer_req_t t;
      t.op           = op;
      t.slot         = SLOT_FLD_W'($urandom);
      t.kind         = 1'($urandom);
      t.interval     = INTERVAL_W'($urandom);
      t.repeat_count = FIRINGS_W'($urandom);
      t.elapsed_ms   = ELAPSED_W'($urandom);
      t.drain_first  = 1'b0;
      t.calm         = 1'b0;
      t.hold         = 1'b0;
      return t;
   endfunction

   function automatic timer_req_t add_req(int slot, bit kind, int interval, int rc);
      timer_req_t t;
      t              = noise_req(OP_ADD);
      t.slot         = SLOT_FLD_W'(slot);
      t.kind         = kind;
      t.interval     = INTERVAL_W'(interval);
      t.repeat_count = FIRINGS_W'(rc);
      return t;
   endfunction

   function automatic timer_req_t tick_req(int elapsed);
      timer_req_t t;
      t            = noise_req(OP_TICK);
      t.elapsed_ms = ELAPSED_W'(elapsed);
      return t;
   endfunction

   function automatic timer_req_t remove_req(int slot);
      timer_req_t t;
      t      = noise_req(OP_REMOVE);
      t.slot = SLOT_FLD_W'(slot);
      return t;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int sender_gap(bit quiet);
      if (quiet || $urandom_range(0, 1) == 0) return 0;
      return idle_length();
   endfunction

   // advance the slot table by one request and queue the expiries it reports
   function void advance_timer_table(input timer_req_t r);
      int    amount;
      fire_t held;
      bit    have_held;
      have_held = 1'b0;
      case (r.op)
         OP_ADD: begin
            tbl_valid[r.slot]  = 1'b1;
            tbl_kind[r.slot]   = r.kind;
            tbl_reload[r.slot] = r.interval;
            tbl_count[r.slot]  = r.interval;
            tbl_left[r.slot]   = r.repeat_count;
         end
         OP_REMOVE: tbl_valid[r.slot] = 1'b0;
         OP_TICK: begin
            for (int pass = 0; pass < 2; pass++) begin
               amount = (pass == 0) ? 1 : int'(r.elapsed_ms);
               for (int s = 0; s < TIMER_SLOTS; s++) begin
                  if (!tbl_valid[s] || int'(tbl_kind[s]) != pass) continue;
                  if (int'(tbl_count[s]) <= amount) begin
                     tbl_count[s] = tbl_reload[s];
                     if (tbl_left[s] != FIRINGS_ENDLESS) begin
                        if (tbl_left[s] <= FIRINGS_ONE || tbl_left[s] >= FIRINGS_SIGN)
                           tbl_valid[s] = 1'b0;
                        else
                           tbl_left[s] = tbl_left[s] - 1'b1;
                     end
                     if (have_held) expected_fires.push_back(held);
                     held.slot = SLOT_FLD_W'(s);
                     held.kind = 1'(pass);
                     held.last = 1'b0;
                     have_held = 1'b1;
                  end else begin
                     tbl_count[s] = tbl_count[s] - INTERVAL_W'(amount);
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_fires.push_back(held);
            end
         end
         default: ;
      endcase
   endfunction

   task report_mismatch(input string what);
      if (errors < PRINT_CAP) $display("%0t: %s", $time, what);
      errors++;
   endtask

   always @(posedge clock) begin : drive_requests
      timer_req_t nxt;
      logic       drive;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive = req_valid;
         if (req_valid && !req_stall) begin
            advance_timer_table(cur_req);
            drive = 1'b0;
         end
         if (!drive) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending.size() > 0 &&
                         !(pending[0].drain_first && expected_fires.size() > 0)) begin
               nxt = pending.pop_front();
               cur_req          <= nxt;
               req_op           <= nxt.op;
               req_slot         <= nxt.slot;
               req_kind         <= nxt.kind;
               req_interval     <= nxt.interval;
               req_repeat_count <= nxt.repeat_count;
               req_elapsed_ms   <= nxt.elapsed_ms;
               gap_left         <= sender_gap(nxt.calm);
               calm             <= nxt.calm;
               if (nxt.hold) hold_req <= 1'b1;
               drive = 1'b1;
            end
         end
         req_valid <= drive;
      end
   end

   always @(posedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         stall_left <= idle_length() - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_results
      fire_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fires.size() == 0) begin
            report_mismatch($sformatf("unexpected expiry of slot %0d", rsp_fired_slot));
         end else begin
            want = expected_fires.pop_front();
            if (rsp_fired_slot !== want.slot)
               report_mismatch($sformatf("fired_slot %0d, predicted %0d",
                                         rsp_fired_slot, want.slot));
            if (rsp_fired_kind !== want.kind)
               report_mismatch($sformatf("fired_kind %0d, predicted %0d for slot %0d",
                                         rsp_fired_kind, want.kind, want.slot));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0d, predicted %0d for slot %0d",
                                         rsp_last, want.last, want.slot));
         end
      end
   end

   initial begin : run_limit
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : run_sequence
      timer_req_t t;
      int         r;
      int         rc;
      int         n_ticks;

      // directed: empty table, unused op, free-slot remove, field extremes
      pending.push_back(tick_req(0));
      pending.push_back(noise_req(OP_UNUSED));
      pending.push_back(remove_req(5));
      pending.push_back(add_req(0, 1'b0, 1, -1));
      pending.push_back(add_req(15, 1'b1, 0, 1));
      pending.push_back(add_req(3, 1'b1, 24'hFFFFFF, 32767));
      pending.push_back(add_req(7, 1'b0, 2, 0));
      pending.push_back(add_req(9, 1'b1, 100, -32768));
      pending.push_back(add_req(11, 1'b0, 0, -2));
      pending.push_back(tick_req(0));
      pending.push_back(tick_req(65535));
      pending.push_back(add_req(0, 1'b1, 5, 2));
      pending.push_back(add_req(4, 1'b0, 1, 2));
      pending.push_back(tick_req(7));
      pending.push_back(remove_req(0));
      pending.push_back(tick_req(1));
      pending.push_back(remove_req(3));
      pending.push_back(noise_req(OP_UNUSED));

      // fill every slot, then hold off the response side under a run of ticks
      for (int s = 0; s < TIMER_SLOTS; s++)
         pending.push_back(add_req(s, 1'($urandom), 1, -1));
      t = tick_req(3);
      t.hold = 1'b1;
      pending.push_back(t);
      for (int k = 0; k < 5; k++) pending.push_back(tick_req($urandom_range(0, 5)));
      t = remove_req(0);
      t.drain_first = 1'b1;
      pending.push_back(t);
      for (int s = 1; s < TIMER_SLOTS; s++) pending.push_back(remove_req(s));

      while (pending.size() < TARGET_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            rc = ($urandom_range(0, 3) == 0) ? -1 : $urandom_range(1, 6);
            if ($urandom_range(0, 1) == 0)
               t = add_req($urandom_range(0, 15), 1'b0, $urandom_range(1, 6), rc);
            else
               t = add_req($urandom_range(0, 15), 1'b1, $urandom_range(1, 300), rc);
            pending.push_back(t);
            n_ticks = $urandom_range(1, 3);
            for (int k = 0; k < n_ticks; k++) begin
               if ($urandom_range(0, 4) == 0) t = tick_req($urandom_range(0, 65535));
               else t = tick_req($urandom_range(0, 120));
               pending.push_back(t);
            end
         end else if (r < 60) begin
            pending.push_back(tick_req($urandom_range(0, 120)));
         end else if (r < 72) begin
            pending.push_back(remove_req($urandom_range(0, 15)));
         end else if (r < 80) begin
            pending.push_back(noise_req(OP_ADD));
         end else if (r < 88) begin
            pending.push_back(noise_req(OP_UNUSED));
         end else if (r < 92) begin
            for (int s = 0; s < TIMER_SLOTS; s++)
               pending.push_back(add_req(s, 1'($urandom), $urandom_range(1, 3),
                                         $urandom_range(1, 2)));
            pending.push_back(tick_req(10));
         end else begin
            pending.push_back(add_req($urandom_range(0, 15), 1'($urandom), 0,
                                      $urandom_range(0, 2)));
            pending.push_back(tick_req(0));
         end
         if ($urandom_range(0, 29) == 0) begin
            t = pending.pop_back();
            t.drain_first = 1'b1;
            pending.push_back(t);
         end
      end

      // run a stretch with no idling on either side
      for (int k = 200; k < 240 && k < pending.size(); k++) begin
         t = pending[k];
         t.calm = 1'b1;
         pending[k] = t;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() > 0 || req_valid) @(posedge clock);
      while (expected_fires.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/mrte_pkg.sv
rtl/core/mrte_slot_mem.sv
rtl/core/multi_slot_repeat_timer_engine.sv
rtl/core/mrte_checker.sv
test/tb_multi_slot_repeat_timer_engine.sv
